FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop on every clk edge outside reset.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check prop on every clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: hdl/hlr_pkg.sv
// ----------------------------------------------------------------------------
// hlr_pkg
// Types and constants for the histogram largest-rectangle block.
// ----------------------------------------------------------------------------
package hlr_pkg;

    localparam int IN_HEIGHT_BITS = 16;
    localparam int AREA_BITS      = 26;
    localparam int COUNT_BITS     = 11;

    typedef struct packed {
        logic [IN_HEIGHT_BITS-1:0] bar_height;
        logic                      last_bar;
    } in_item_t;

    typedef struct packed {
        logic [AREA_BITS-1:0]  max_area;
        logic [COUNT_BITS-1:0] bar_count;
        logic                  overflow;
    } out_item_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_POP   = 6'b000100,
        S_SCORE = 6'b001000,
        S_FLUSH = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;  // latch the input beat
        logic push;     // push bar, advance position
        logic drop;     // mark dropped bar
        logic pop;      // pop top, form product
        logic score;    // fold product into best area
        logic emit;     // load result, clear histogram state
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic top_ge;   // stack not empty and top height >= new bar
        logic full;     // position reached capacity
        logic empty;    // stack empty
        logic last;     // captured bar closes the histogram
        logic out_busy; // result slot occupied and not taken this cycle
    } sts_t;

endpackage

FILE: hdl/hlr_ctrl.sv
// ----------------------------------------------------------------------------
// hlr_ctrl
// Sequencer for push, pop, score and flush steps of the stack walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hlr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  hlr_pkg::sts_t sts,
    output hlr_pkg::cmd_t cmd
);
    import hlr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   flush_reg;
    logic   flush_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.full)
                begin
                    cmd.drop   = 1'b1;
                    state_next = sts.last ? S_FLUSH : S_IDLE;
                end
                else if (sts.top_ge)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = sts.last ? S_FLUSH : S_IDLE;
                end
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = S_SCORE;
            end
            S_SCORE:
            begin
                cmd.score  = 1'b1;
                state_next = flush_reg ? S_FLUSH : S_CHECK;
            end
            S_FLUSH:
            begin
                flush_next = 1'b1;
                state_next = sts.empty ? S_DONE : S_POP;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    flush_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                flush_next = 1'b0;
            end
        endcase
    end

    `ASSERT_RST(a_pop_nonempty, cmd.pop |-> !sts.empty, "pop on empty stack")
    `ASSERT_RST(a_emit_free, cmd.emit |-> !sts.out_busy, "result slot overwritten")
    `ASSERT_RST(a_push_room, cmd.push |-> !sts.full, "push beyond capacity")
    `ASSERT_RST(a_one_item, cmd.capture |=> !in_ready, "second beat taken mid-item")

endmodule

FILE: hdl/hlr_dp.sv
// ----------------------------------------------------------------------------
// hlr_dp
// Stack memory, top-of-stack registers, area multiplier and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hlr_dp #(
    parameter int MAX_BARS    = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hlr_pkg::in_item_t  in_data,
    input  hlr_pkg::cmd_t      cmd,
    output hlr_pkg::sts_t      sts,
    output logic               out_valid,
    input  logic               out_ready,
    output hlr_pkg::out_item_t out_data
);
    import hlr_pkg::*;

    localparam int HW     = (HEIGHT_BITS < IN_HEIGHT_BITS) ? HEIGHT_BITS : IN_HEIGHT_BITS;
    localparam int AD     = $clog2(MAX_BARS);
    localparam int PW     = $clog2(MAX_BARS + 1);
    localparam int AW     = HW + PW;
    localparam int SAT_AW = (AW > AREA_BITS) ? AW : AREA_BITS;
    localparam int SAT_CW = (PW > COUNT_BITS) ? PW : COUNT_BITS;

    localparam logic [PW-1:0]     MAX_POS   = PW'(MAX_BARS);
    localparam logic [PW-1:0]     ONE_P     = PW'(1);
    localparam logic [PW-1:0]     TWO_P     = PW'(2);
    localparam logic [SAT_AW-1:0] AREA_MAX  = SAT_AW'((64'd1 << AREA_BITS) - 64'd1);
    localparam logic [SAT_CW-1:0] COUNT_MAX = SAT_CW'((64'd1 << COUNT_BITS) - 64'd1);

    // Stack below the top entry: {height, position}
    logic [HW+AD-1:0] stack_mem [MAX_BARS];
    logic [HW+AD-1:0] rd_reg;

    logic [PW-1:0] fill_reg, fill_next;
    logic [PW-1:0] pos_reg,  pos_next;
    logic [AW-1:0] best_reg, best_next;
    logic          drop_reg, drop_next;
    logic          out_valid_reg, out_valid_next;

    logic [HW-1:0] top_h_reg;
    logic [AD-1:0] top_p_reg;
    logic [HW-1:0] h_in_reg;
    logic          last_reg;
    logic [AW-1:0] prod_reg;
    out_item_t     out_data_reg;

    logic [PW-1:0]     wr_full, rd_full, width;
    logic [AD-1:0]     wr_addr, rd_addr;
    logic [HW-1:0]     below_h;
    logic [AD-1:0]     below_p;
    logic [AW-1:0]     prod;
    logic [SAT_AW-1:0] best_ext;
    logic [SAT_CW-1:0] count_ext;

    assign wr_full = fill_reg - ONE_P;
    assign rd_full = fill_reg - TWO_P;
    assign wr_addr = wr_full[AD-1:0];
    assign rd_addr = rd_full[AD-1:0];
    assign below_h = rd_reg[HW+AD-1:AD];
    assign below_p = rd_reg[AD-1:0];

    // Width runs from just above the entry below up to just before pos
    assign width = (fill_reg == ONE_P) ? pos_reg : (pos_reg - PW'(below_p) - ONE_P);
    assign prod  = AW'(top_h_reg) * AW'(width);

    always_ff @(posedge clk)
    begin
        if (cmd.push && (fill_reg != '0))
        begin
            stack_mem[wr_addr] <= {top_h_reg, top_p_reg};
        end
        rd_reg <= stack_mem[rd_addr];
    end

    always_comb
    begin
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        best_next      = best_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.push)
        begin
            fill_next = fill_reg + ONE_P;
            pos_next  = pos_reg + ONE_P;
        end
        if (cmd.drop)
        begin
            drop_next = 1'b1;
        end
        if (cmd.pop)
        begin
            fill_next = wr_full;
        end
        if (cmd.score && (prod_reg > best_reg))
        begin
            best_next = prod_reg;
        end
        if (cmd.emit)
        begin
            fill_next      = '0;
            pos_next       = '0;
            best_next      = '0;
            drop_next      = 1'b0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            pos_reg       <= '0;
            best_reg      <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            best_reg      <= best_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign best_ext  = SAT_AW'(best_reg);
    assign count_ext = SAT_CW'(pos_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            h_in_reg <= in_data.bar_height[HW-1:0];
            last_reg <= in_data.last_bar;
        end
        if (cmd.push)
        begin
            top_h_reg <= h_in_reg;
            top_p_reg <= pos_reg[AD-1:0];
        end
        if (cmd.pop)
        begin
            prod_reg  <= prod;
            top_h_reg <= below_h;
            top_p_reg <= below_p;
        end
        if (cmd.emit)
        begin
            out_data_reg.max_area  <= (best_ext > AREA_MAX) ? AREA_BITS'(AREA_MAX)
                                                            : best_ext[AREA_BITS-1:0];
            out_data_reg.bar_count <= (count_ext > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX)
                                                              : count_ext[COUNT_BITS-1:0];
            out_data_reg.overflow  <= drop_reg;
        end
    end

    assign sts.top_ge   = (fill_reg != '0) && (top_h_reg >= h_in_reg);
    assign sts.full     = (pos_reg >= MAX_POS);
    assign sts.empty    = (fill_reg == '0);
    assign sts.last     = last_reg;
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_RST(a_fill_le_pos, fill_reg <= pos_reg, "stack deeper than bar count")
    `ASSERT_RST(a_pos_cap, pos_reg <= MAX_POS, "position past capacity")
    `ASSERT_RST(a_emit_clear, cmd.emit |=> (fill_reg == '0) && (pos_reg == '0) && out_valid,
                "histogram state not cleared on emit")

endmodule

FILE: hdl/histogram_largest_rectangle.sv
// ----------------------------------------------------------------------------
// histogram_largest_rectangle
// Largest rectangle under a streamed histogram, using a monotonic stack.
// ----------------------------------------------------------------------------
// Feed bar heights one beat at a time and mark the final bar with last_bar;
// one result beat (max_area, bar_count, overflow) follows each final bar and
// nothing else is ever emitted. Only the low HEIGHT_BITS bits of bar_height
// count. At most MAX_BARS bars are taken per histogram; later bars are dropped
// and set overflow, and a dropped final bar still closes the histogram. Timing
// is set by one shared multiplier and the registered read of the stack memory:
// a bar takes the beat, then compares and pushes, and each stack entry it
// pops adds a multiply, a fold into the best area and a fresh compare. Every
// bar that is taken is pushed once and popped once, the pops of the final
// flush included. The next bar is taken while an earlier result still waits
// in the output register; only the closing step of a histogram stalls on an
// unread result. No clearing pass is needed after reset: a stack read is
// used only below its fill level.
// ----------------------------------------------------------------------------
module histogram_largest_rectangle #(
    parameter int MAX_BARS    = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hlr_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hlr_pkg::out_item_t out_data
);
    import hlr_pkg::*;

    // Command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // Sequencer: walks push, pop/score and flush steps
    hlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: stack, multiplier, best area and the result register
    hlr_dp #(
        .MAX_BARS    (MAX_BARS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
